// ----- src/bounded_list_engine_with_search_defines.svh -----
// ----------------------------------------------------------------------------
// Bounded list engine assertion macros
// Concurrent assertion wrappers for the list engine; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_ENGINE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_LIST_ENGINE_WITH_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge out of reset.
`define BLES_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define BLES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BLES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BLES_ASSERT(label, clk, rst, prop, msg)
`define BLES_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define BLES_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- src/bles_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded list engine package
// Field widths, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package bles_pkg;

  localparam int DEF_LIST_DEPTH  = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int OP_W         = 3;
  localparam int VALUE_PORT_W = 32;
  localparam int STATUS_W     = 2;
  localparam int POS_W        = 4;
  localparam int LEN_W        = 5;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd4;
  localparam logic [OP_W-1:0] OP_REVERSE   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_PUSH   = 4'b1000
  } state_t;

endpackage

// ----- src/bles_if.sv -----
// ----------------------------------------------------------------------------
// Bounded list engine channels
// Valid/ready request and response interfaces with their payload fields.
// ----------------------------------------------------------------------------
interface bles_req_if;
  import bles_pkg::*;

  logic                           valid;
  logic                           ready;
  logic        [OP_W-1:0]         op;
  logic signed [VALUE_PORT_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface bles_rsp_if;
  import bles_pkg::*;

  logic                           valid;
  logic                           ready;
  logic        [STATUS_W-1:0]     status;
  logic signed [VALUE_PORT_W-1:0] removed_value;
  logic        [POS_W-1:0]        position;
  logic        [LEN_W-1:0]        length;

  modport source (output valid, output status, output removed_value, output position,
                  output length, input ready);
  modport sink   (input valid, input status, input removed_value, input position,
                  input length, output ready);
endinterface

// ----- src/bounded_list_engine_with_search.sv -----
// ----------------------------------------------------------------------------
// Bounded list engine with search
// Ordered list in a ring RAM: push/pop at either end, key search, reverse.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   op, value
//  rsp      out  valid/ready   status, removed_value, position, length
//
//  One request at a time. Insert, reverse and no-op go from idle through the
//  push state to the result register; delete adds a read state (one RAM read).
//  Search walks from the logical front until a hit or the last of up to
//  LIST_DEPTH entries, the single RAM read port walking one entry per cycle.
//  The result register lets the next request in while a response waits; a
//  finished request stalls in its push state until the result register frees.
//  Synchronous reset clears pointer, count and direction; the RAM is not
//  cleared, so the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
`include "bounded_list_engine_with_search_defines.svh"

module bounded_list_engine_with_search #(
  parameter int LIST_DEPTH  = bles_pkg::DEF_LIST_DEPTH,
  parameter int VALUE_WIDTH = bles_pkg::DEF_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  bles_req_if.sink   req,
  bles_rsp_if.source rsp
);
  import bles_pkg::*;

  localparam int PTR_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(LIST_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(LIST_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_PTR : PTR_W'(p - 1'b1);
  endfunction

  // off is at most LIST_DEPTH, so one conditional subtract wraps it
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return PTR_W'(sum);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] to_store(input logic signed [VALUE_PORT_W-1:0] v);
    return VALUE_WIDTH'(v);
  endfunction

  state_t state;

  logic [PTR_W-1:0] front_ptr;
  logic [CNT_W-1:0] cnt;
  logic             rev;

  logic [VALUE_WIDTH-1:0] key;
  logic [PTR_W-1:0]       walk_slot;
  logic [PTR_W-1:0]       srch_idx;

  logic [STATUS_W-1:0]     res_status;
  logic [VALUE_PORT_W-1:0] res_removed;
  logic [POS_W-1:0]        res_pos;
  logic [LEN_W-1:0]        res_len;

  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [VALUE_PORT_W-1:0] out_removed;
  logic [POS_W-1:0]        out_pos;
  logic [LEN_W-1:0]        out_len;

  logic                   acc;
  logic                   push;
  logic                   is_ins, is_del;
  logic                   nat_front_ins, nat_front_del;
  logic                   full, empty;
  logic [PTR_W-1:0]       before_front, back_ins_slot, last_slot, walk_next;
  logic                   ram_we;
  logic [PTR_W-1:0]       ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                   hit, walk_last;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;

  // result register takes the finished request when empty or draining
  assign push      = (state == S_PUSH) && (!out_valid || rsp.ready);

  assign is_ins        = (req.op == OP_INS_FRONT) || (req.op == OP_INS_BACK);
  assign is_del        = (req.op == OP_DEL_FRONT) || (req.op == OP_DEL_BACK);
  assign nat_front_ins = (req.op == OP_INS_FRONT) != rev;
  assign nat_front_del = (req.op == OP_DEL_FRONT) != rev;
  assign full          = (cnt == CNT_W'(LIST_DEPTH));
  assign empty         = (cnt == '0);

  assign before_front  = ring_dec(front_ptr);
  assign back_ins_slot = ring_add(front_ptr, cnt);
  assign last_slot     = ring_add(front_ptr, CNT_W'(cnt - 1'b1));
  assign walk_next     = rev ? ring_dec(walk_slot) : ring_inc(walk_slot);

  assign ram_we    = acc && is_ins && !full;
  assign ram_waddr = nat_front_ins ? before_front : back_ins_slot;
  assign ram_wdata = to_store(req.value);

  // search walks from the logical front; reversed order starts at the ring tail
  always_comb begin
    priority if (state == S_SEARCH) begin
      ram_raddr = walk_next;
    end else if (is_del) begin
      ram_raddr = nat_front_del ? front_ptr : last_slot;
    end else begin
      ram_raddr = rev ? last_slot : front_ptr;
    end
  end

  assign hit       = (ram_rdata == key);
  assign walk_last = (CNT_W'(srch_idx) == CNT_W'(cnt - 1'b1));

  bles_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (VALUE_WIDTH),
    .AW    (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_ptr <= '0;
      cnt       <= '0;
      rev       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            res_status  <= ST_OK;
            res_removed <= '0;
            res_pos     <= '0;
            res_len     <= LEN_W'(cnt);
            state       <= S_PUSH;
            priority if (is_ins) begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                if (nat_front_ins) begin
                  front_ptr <= before_front;
                end
                cnt     <= CNT_W'(cnt + 1'b1);
                res_len <= LEN_W'(cnt + 1'b1);
              end
            end else if (is_del) begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                if (nat_front_del) begin
                  front_ptr <= ring_inc(front_ptr);
                end
                cnt     <= CNT_W'(cnt - 1'b1);
                res_len <= LEN_W'(cnt - 1'b1);
                state   <= S_READ;
              end
            end else if (req.op == OP_SEARCH) begin
              key <= to_store(req.value);
              if (empty) begin
                res_status <= ST_NOTFOUND;
              end else begin
                walk_slot <= ram_raddr;
                srch_idx  <= '0;
                state     <= S_SEARCH;
              end
            end else if (req.op == OP_REVERSE) begin
              rev <= !rev;
            end else begin
              // unused codes: plain ok response
            end
          end
        end
        S_READ: begin
          res_removed <= VALUE_PORT_W'(ram_rdata);
          state       <= S_PUSH;
        end
        S_SEARCH: begin
          // ram_rdata holds the entry at logical index srch_idx
          priority if (hit) begin
            res_status <= ST_OK;
            res_pos    <= POS_W'(srch_idx);
            state      <= S_PUSH;
          end else if (walk_last) begin
            res_status <= ST_NOTFOUND;
            state      <= S_PUSH;
          end else begin
            srch_idx  <= PTR_W'(srch_idx + 1'b1);
            walk_slot <= walk_next;
          end
        end
        S_PUSH: begin
          if (push) begin
            out_status  <= res_status;
            out_removed <= res_removed;
            out_pos     <= res_pos;
            out_len     <= res_len;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.removed_value = signed'(out_removed);
  assign rsp.position      = out_pos;
  assign rsp.length        = out_len;

  `BLES_ASSERT(a_cnt_bound, clk, rst, cnt <= CNT_W'(LIST_DEPTH), "entry count above depth")
  `BLES_ASSERT(a_ptr_bound, clk, rst, front_ptr <= LAST_PTR, "front pointer outside ring")
  `BLES_ASSERT_IMPL(a_walk_bound, clk, rst, state == S_SEARCH, CNT_W'(srch_idx) < cnt, "search index past list end")
  `BLES_ASSERT_NEXT(a_ins_count, clk, rst, acc && is_ins && !full, cnt == $past(cnt) + 1'b1, "insert did not grow list")
  `BLES_ASSERT_IMPL(a_rsp_from_push, clk, rst, $rose(rsp.valid), $past(state == S_PUSH), "response raised outside push state")

endmodule

// ----- src/bles_ram.sv -----
// ----------------------------------------------------------------------------
// Bounded list entry store
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bles_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
